>>> rtl/fst_pkg.sv
// Shared types and constants of the flow statistics table.
package fst_pkg;

   localparam int KEY_W      = 40;
   localparam int STAT_W     = 64;
   localparam int METRIC_W   = 5 * STAT_W;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [16:0] ETH_HDR_BYTES  = 17'd14;
   localparam logic [16:0] IPV4_MIN_BYTES = 17'd20;
   localparam logic [16:0] PORT_BYTES     = 17'd4;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam logic [1:0] STATUS_IGNORED = 2'd0;
   localparam logic [1:0] STATUS_NEW     = 2'd1;
   localparam logic [1:0] STATUS_UPDATED = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic              ignore;
      logic [KEY_W-1:0]  key;
      logic [31:0]       packet_len;
      logic [63:0]       now_ns;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CMP,
      S_INSERT,
      S_MREAD,
      S_MCALC,
      S_UPDATE,
      S_RESP
   } state_type;

endpackage

>>> rtl/fst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fst_front.sv
// Front end: checks the frame and builds the flow key.
module fst_front import fst_pkg::*; (
   input  logic [15:0] captured_len,
   input  logic [15:0] ethertype,
   input  logic [3:0]  ip_header_words,
   input  logic [7:0]  ip_protocol,
   input  logic [15:0] l4_src_port,
   input  logic [15:0] l4_dst_port,
   input  logic [31:0] packet_len,
   input  logic [63:0] now_ns,
   output cmd_type     cmd
);

   logic [16:0] cap;
   logic [16:0] l4_end;
   logic        has_ports;
   logic        bad_frame;
   logic [15:0] sport;
   logic [15:0] dport;

   always_comb begin
      cap       = {1'b0, captured_len};
      l4_end    = ETH_HDR_BYTES + {11'd0, ip_header_words, 2'b00} + PORT_BYTES;
      has_ports = (ip_protocol == PROTO_TCP) || (ip_protocol == PROTO_UDP);
      bad_frame = (ethertype != ETHERTYPE_IPV4) || (cap < ETH_HDR_BYTES + IPV4_MIN_BYTES)
                  || (has_ports && (l4_end > cap));
      sport     = has_ports ? l4_src_port : 16'd0;
      dport     = has_ports ? l4_dst_port : 16'd0;
      cmd.ignore     = bad_frame;
      cmd.key        = {ip_protocol, sport, dport};
      cmd.packet_len = packet_len;
      cmd.now_ns     = now_ns;
   end

endmodule

>>> rtl/fst_fifo.sv
// Two-entry queue between front end and table engine.
module fst_fifo import fst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

endmodule

>>> rtl/fst_back.sv
// Table engine: key scan, insert or metric update, result register.
module fst_back import fst_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_flow_packets,
   output logic [63:0] rsp_flow_bytes,
   output logic [63:0] rsp_flow_first_seen,
   output logic [63:0] rsp_flow_last_seen,
   output logic [63:0] rsp_gap_sum
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

   state_type state_ff, state_in;
   cmd_type   cmd_ff;
   logic [OCC_W-1:0] idx_ff, idx_next;
   logic [OCC_W-1:0] occ_ff;
   logic [63:0] pk_ff, by_ff, fs_ff, gs_ff, diff_ff;
   logic [1:0]  res_status_ff;
   logic [63:0] res_pk_ff, res_by_ff, res_fs_ff, res_ls_ff, res_gs_ff;

   logic                key_wr_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    met_wr_addr;
   logic [KEY_W-1:0]    key_rd_data;
   logic                met_wr_en;
   logic [METRIC_W-1:0] met_wr_data;
   logic [METRIC_W-1:0] met_rd_data;
   logic                table_full;
   logic                key_match;
   logic [63:0]         gap_new;

   fst_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (occ_ff[IDX_W-1:0]),
      .wr_data (cmd_ff.key),
      .rd_addr (rd_addr),
      .rd_data (key_rd_data)
   );

   fst_ram #(.WIDTH(METRIC_W), .DEPTH(TABLE_ENTRIES)) u_metric_ram (
      .clock   (clock),
      .wr_en   (met_wr_en),
      .wr_addr (met_wr_addr),
      .wr_data (met_wr_data),
      .rd_addr (rd_addr),
      .rd_data (met_rd_data)
   );

   always_comb begin
      table_full = (occ_ff == OCC_W'(TABLE_ENTRIES));
      key_match  = (key_rd_data == cmd_ff.key);
      idx_next   = idx_ff + OCC_W'(1);
      gap_new    = gs_ff + diff_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.ignore) begin
                  state_in = S_RESP;
               end else if (occ_ff == '0) begin
                  state_in = S_INSERT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN:   state_in = S_CMP;
         S_CMP: begin
            if (key_match) begin
               state_in = S_MREAD;
            end else if (idx_next == occ_ff) begin
               state_in = S_INSERT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_INSERT: state_in = S_RESP;
         S_MREAD:  state_in = S_MCALC;
         S_MCALC:  state_in = S_UPDATE;
         S_UPDATE: state_in = S_RESP;
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = (state_ff == S_IDLE) && cmd_valid;
      rd_addr     = idx_ff[IDX_W-1:0];
      key_wr_en   = (state_ff == S_INSERT) && !table_full;
      met_wr_en   = key_wr_en || (state_ff == S_UPDATE);
      met_wr_addr = (state_ff == S_INSERT) ? occ_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
      if (state_ff == S_INSERT) begin
         met_wr_data = {64'd1, {32'd0, cmd_ff.packet_len}, cmd_ff.now_ns, cmd_ff.now_ns,
                        64'd0};
      end else begin
         met_wr_data = {pk_ff, by_ff, fs_ff, cmd_ff.now_ns, gap_new};
      end
      rsp_valid = (state_ff == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (key_wr_en) begin
            occ_ff <= occ_ff + OCC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ff        <= cmd;
               idx_ff        <= '0;
               res_status_ff <= STATUS_IGNORED;
               res_pk_ff     <= '0;
               res_by_ff     <= '0;
               res_fs_ff     <= '0;
               res_ls_ff     <= '0;
               res_gs_ff     <= '0;
            end
         end
         S_CMP: begin
            if (!key_match) begin
               idx_ff <= idx_next;
            end
         end
         S_INSERT: begin
            if (table_full) begin
               res_status_ff <= STATUS_FULL;
            end else begin
               res_status_ff <= STATUS_NEW;
               res_pk_ff     <= 64'd1;
               res_by_ff     <= {32'd0, cmd_ff.packet_len};
               res_fs_ff     <= cmd_ff.now_ns;
               res_ls_ff     <= cmd_ff.now_ns;
               res_gs_ff     <= '0;
            end
         end
         S_MCALC: begin
            pk_ff   <= met_rd_data[5*STAT_W-1:4*STAT_W] + 64'd1;
            by_ff   <= met_rd_data[4*STAT_W-1:3*STAT_W] + {32'd0, cmd_ff.packet_len};
            fs_ff   <= met_rd_data[3*STAT_W-1:2*STAT_W];
            diff_ff <= cmd_ff.now_ns - met_rd_data[2*STAT_W-1:STAT_W];
            gs_ff   <= met_rd_data[STAT_W-1:0];
         end
         S_UPDATE: begin
            res_status_ff <= STATUS_UPDATED;
            res_pk_ff     <= pk_ff;
            res_by_ff     <= by_ff;
            res_fs_ff     <= fs_ff;
            res_ls_ff     <= cmd_ff.now_ns;
            res_gs_ff     <= gap_new;
         end
         default: begin
         end
      endcase
   end

   assign rsp_status          = res_status_ff;
   assign rsp_flow_packets    = res_pk_ff;
   assign rsp_flow_bytes      = res_by_ff;
   assign rsp_flow_first_seen = res_fs_ff;
   assign rsp_flow_last_seen  = res_ls_ff;
   assign rsp_gap_sum         = res_gs_ff;

endmodule

>>> rtl/flow_stats_table_unit.sv
// Flow statistics table: top level joining front end, queue and table engine.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    frame header words, length, timestamp
//   rsp_      out        rsp_valid/rsp_ready    status and flow metrics
//
// A transaction waits in the queue, then the engine scans the key RAM, with a SCAN
// and a CMP state per entry. A hit reads, calcs and writes the metric RAM; a miss or
// an empty table goes to INSERT, which adds the flow or, if the table is full, gives
// FULL. An ignored frame goes straight to the result. The result cycle stretches
// while rsp_ready is low. Reset clears the flow count; no clearing pass is needed.
// The two-entry queue takes transactions until full while a result waits on rsp_ready.
module flow_stats_table_unit import fst_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_captured_len,
   input  logic [15:0] req_ethertype,
   input  logic [3:0]  req_ip_header_words,
   input  logic [7:0]  req_ip_protocol,
   input  logic [15:0] req_l4_src_port,
   input  logic [15:0] req_l4_dst_port,
   input  logic [31:0] req_packet_len,
   input  logic [63:0] req_now_ns,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_flow_packets,
   output logic [63:0] rsp_flow_bytes,
   output logic [63:0] rsp_flow_first_seen,
   output logic [63:0] rsp_flow_last_seen,
   output logic [63:0] rsp_gap_sum
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;

   fst_front u_front (
      .captured_len    (req_captured_len),
      .ethertype       (req_ethertype),
      .ip_header_words (req_ip_header_words),
      .ip_protocol     (req_ip_protocol),
      .l4_src_port     (req_l4_src_port),
      .l4_dst_port     (req_l4_dst_port),
      .packet_len      (req_packet_len),
      .now_ns          (req_now_ns),
      .cmd             (front_cmd)
   );

   assign req_ready = !q_full;

   fst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   fst_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (q_not_empty),
      .cmd                 (head_cmd),
      .cmd_pop             (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_flow_packets    (rsp_flow_packets),
      .rsp_flow_bytes      (rsp_flow_bytes),
      .rsp_flow_first_seen (rsp_flow_first_seen),
      .rsp_flow_last_seen  (rsp_flow_last_seen),
      .rsp_gap_sum         (rsp_gap_sum)
   );

endmodule

>>> rtl/fst_checker.sv
// Port-level checks of the flow statistics table and their binding.
module fst_checker import fst_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_flow_packets,
   input logic [63:0] rsp_flow_bytes,
   input logic [63:0] rsp_flow_first_seen,
   input logic [63:0] rsp_flow_last_seen,
   input logic [63:0] rsp_gap_sum
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flow_bytes))
      else $error("result dropped while stalled");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_IGNORED || rsp_status == STATUS_FULL)
      |-> rsp_flow_packets == 64'd0 && rsp_flow_bytes == 64'd0 && rsp_gap_sum == 64'd0)
      else $error("metrics not zero for dropped transaction");

   a_new_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NEW
      |-> rsp_flow_packets == 64'd1 && rsp_gap_sum == 64'd0
          && rsp_flow_first_seen == rsp_flow_last_seen)
      else $error("new flow metrics wrong");

   a_bytes_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NEW |-> rsp_flow_bytes[63:32] == 32'd0)
      else $error("new flow byte count too wide");

endmodule

bind flow_stats_table_unit fst_checker u_fst_checker (.*);
